// ----- design/rvd_pkg.sv -----
`default_nettype none
package rvd_pkg;

  localparam int MAX_LINES_DEF = 16;
  localparam int ADDR_BITS_DEF = 24;
  localparam int GRP_FIFO_DEPTH = 4;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_RTP   = 2'd1;
  localparam logic [1:0] PH_LINES = 2'd2;
  localparam logic [1:0] PH_DATA  = 2'd3;

  localparam logic [3:0] RTP_SKIP = 4'd14;
  localparam logic [2:0] LAST_HDR_POS = 3'd5;
  localparam logic [2:0] LAST_GRP_POS = 3'd5;

  localparam logic [1:0] CFG_STRIDE = 2'd0;
  localparam logic [1:0] CFG_XOFF   = 2'd1;
  localparam logic [1:0] CFG_YOFF   = 2'd2;

  localparam logic [12:0] STRIDE_RST = 13'd1024;

  localparam logic signed [27:0] K_CR_R = 28'sd91881;
  localparam logic signed [27:0] K_CB_G = 28'sd22554;
  localparam logic signed [27:0] K_CR_G = 28'sd46802;
  localparam logic signed [27:0] K_CB_B = 28'sd116130;
  localparam logic [8:0] CHROMA_MID = 9'd128;

  typedef struct packed {
    logic [31:0] ys;      // y00 in low byte
    logic [7:0]  cb;
    logic [7:0]  cr;
    logic [14:0] line;
    logic [15:0] col;
  } grp_t;

  function automatic logic [7:0] clamp8(input logic signed [27:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 28'sh0ffffff) begin
      r = 8'hff;
    end else begin
      r = v[23:16];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/raw_video_depacketizer_ycbcr420_top.sv -----
`default_nettype none
// RTP raw-video depacketizer for 8-bit YCbCr 4:2:0: takes one packet byte per cycle on push
// and turns each six-byte payload group into four frame-buffer pixel writes, one per cycle
// on the result side while pop is held, so a line of payload streams through at full byte
// rate. The parser tracks headers and line table in the front; full rises only when the
// four-entry group queue between the parser and the color/address pipeline is full. A group
// passes the group queue, group register, stage 1, stage 2 and output register in order.
module raw_video_depacketizer_ycbcr420_top import rvd_pkg::*; #(
  parameter int MAX_LINES = MAX_LINES_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        packet_start_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [23:0]      pixel_address_o,
  output logic [23:0]      pixel_rgb_o,
  output logic             last_of_group_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [12:0] cfg_data_i
);
  logic [12:0] stride_q;
  logic [11:0] xoff_q, yoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= STRIDE_RST;
      xoff_q <= '0;
      yoff_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STRIDE: stride_q <= cfg_data_i;
        CFG_XOFF:   xoff_q <= cfg_data_i[11:0];
        CFG_YOFF:   yoff_q <= cfg_data_i[11:0];
        default: begin
        end
      endcase
    end
  end

  logic acc, grp_push, grp_full, grp_pop, grp_empty;
  grp_t grp_w, grp_r;

  assign full = grp_full;
  assign acc = push && !grp_full;

  rvd_front #(.MAX_LINES(MAX_LINES)) u_front (
    .clk_i, .rst_ni,
    .acc_i(acc),
    .data_byte_i,
    .packet_start_i,
    .grp_push_o(grp_push),
    .grp_o(grp_w)
  );

  rvd_fifo #(.DEPTH(GRP_FIFO_DEPTH)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(grp_push),
    .wdata_i(grp_w),
    .full_o(grp_full),
    .pop_i(grp_pop),
    .rdata_o(grp_r),
    .empty_o(grp_empty)
  );

  rvd_back #(.ADDR_BITS(ADDR_BITS)) u_back (
    .clk_i, .rst_ni,
    .grp_i(grp_r),
    .grp_empty_i(grp_empty),
    .grp_pop_o(grp_pop),
    .line_stride_i(stride_q),
    .x_offset_i(xoff_q),
    .y_offset_i(yoff_q),
    .empty_o(empty),
    .pop_i(pop),
    .pixel_address_o,
    .pixel_rgb_o,
    .last_of_group_o
  );

`ifndef SYNTH
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_push |-> !grp_full) else $error("group queue overrun");
  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_pop |-> !grp_empty) else $error("group queue underrun");
  a_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(pixel_rgb_o) && $stable(pixel_address_o)))
    else $error("pending pixel lost");
`endif
endmodule
`default_nettype wire

// ----- design/rvd_fifo.sv -----
`default_nettype none
module rvd_fifo import rvd_pkg::*; #(
  parameter int DEPTH = GRP_FIFO_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire grp_t wdata_i,
  output logic      full_o,
  input  wire logic pop_i,
  output grp_t      rdata_o,
  output logic      empty_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  grp_t mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q, wp_d, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_comb begin
    wp_d = wp_q;
    rp_d = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop_i) begin
      rp_d = (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end
endmodule
`default_nettype wire

// ----- design/rvd_front.sv -----
`default_nettype none
module rvd_front import rvd_pkg::*; #(
  parameter int MAX_LINES = MAX_LINES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       acc_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       packet_start_i,
  output logic            grp_push_o,
  output grp_t            grp_o
);
  localparam int LW = $clog2(MAX_LINES + 1);
  localparam int IW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

  logic [15:0] len_tab_q  [MAX_LINES];
  logic [14:0] line_tab_q [MAX_LINES];
  logic [14:0] offs_tab_q [MAX_LINES];

  logic [1:0]  ph_q, ph_d;
  logic [3:0]  hdr_q, hdr_d;
  logic [2:0]  pos_q, pos_d;
  logic [47:0] asm_q, asm_d;
  logic [LW-1:0] lines_q, lines_d;
  logic [LW-1:0] cur_q, cur_d;
  logic [15:0] left_q, left_d;
  logic [15:0] col_q, col_d;
  logic [39:0] gb_q, gb_d;

  logic          tab_we;
  logic [47:0]   hdr_word;
  logic          do_enter;
  logic [LW-1:0] enter_from;
  logic [LW-1:0] enter_stored;
  logic          found;
  logic [IW-1:0] found_idx;
  logic [15:0]   found_len;
  logic [14:0]   found_offs;

  // lowest stored line at or after enter_from with nonzero length
  always_comb begin
    found = 1'b0;
    found_idx = '0;
    for (int i = MAX_LINES - 1; i >= 0; i--) begin
      logic [15:0] l;
      l = (tab_we && lines_q == LW'(i)) ? hdr_word[47:32] : len_tab_q[i];
      if (LW'(i) >= enter_from && LW'(i) < enter_stored && l != 16'd0) begin
        found = 1'b1;
        found_idx = IW'(i);
      end
    end
    if (tab_we && lines_q[IW-1:0] == found_idx) begin
      found_len = hdr_word[47:32];
      found_offs = hdr_word[14:0];
    end else begin
      found_len = len_tab_q[found_idx];
      found_offs = offs_tab_q[found_idx];
    end
  end

  always_comb begin
    logic [1:0]    ph_e;
    logic [3:0]    hdr_e;
    logic [2:0]    pos_e;
    logic [47:0]   asm_e;
    logic [LW-1:0] lines_e;
    logic [LW-1:0] cur_e;
    logic [15:0]   left_e;
    logic [15:0]   col_e;
    logic [39:0]   gb_e;
    ph_e = ph_q; hdr_e = hdr_q; pos_e = pos_q; asm_e = asm_q; lines_e = lines_q;
    cur_e = cur_q; left_e = left_q; col_e = col_q; gb_e = gb_q;
    if (acc_i && packet_start_i) begin
      ph_e = PH_RTP; hdr_e = '0; pos_e = '0; asm_e = '0; lines_e = '0;
      cur_e = '0; left_e = '0; col_e = '0; gb_e = '0;
    end
    ph_d = ph_e; hdr_d = hdr_e; pos_d = pos_e; asm_d = asm_e; lines_d = lines_e;
    cur_d = cur_e; left_d = left_e; col_d = col_e; gb_d = gb_e;
    tab_we = 1'b0;
    hdr_word = {asm_e[39:0], data_byte_i};
    do_enter = 1'b0;
    enter_from = '0;
    enter_stored = lines_e;
    grp_push_o = 1'b0;
    grp_o.ys = gb_e[31:0];
    grp_o.cb = gb_e[39:32];
    grp_o.cr = data_byte_i;
    grp_o.line = line_tab_q[cur_e[IW-1:0]];
    grp_o.col = col_e;

    if (acc_i) begin
      case (ph_e)
        PH_RTP: begin
          hdr_d = hdr_e + 1'b1;
          if (hdr_e + 1'b1 >= RTP_SKIP) begin
            ph_d = PH_LINES;
            pos_d = '0;
            asm_d = '0;
          end
        end
        PH_LINES: begin
          asm_d = hdr_word;
          pos_d = pos_e + 1'b1;
          if (pos_e == LAST_HDR_POS) begin
            pos_d = '0;
            asm_d = '0;
            if (lines_e >= LW'(MAX_LINES)) begin
              ph_d = PH_IDLE;
            end else begin
              tab_we = 1'b1;
              lines_d = lines_e + 1'b1;
              if (!hdr_word[15]) begin
                ph_d = PH_DATA;
                do_enter = 1'b1;
                enter_from = '0;
                enter_stored = lines_e + 1'b1;
              end
            end
          end
        end
        PH_DATA: begin
          if (pos_e != LAST_GRP_POS) begin
            gb_d[8*pos_e +: 8] = data_byte_i;
            pos_d = pos_e + 1'b1;
          end else begin
            grp_push_o = 1'b1;
            col_d = col_e + 16'd2;
            pos_d = '0;
            gb_d = '0;
          end
          left_d = left_e - 1'b1;
          if (left_e == 16'd1) begin
            do_enter = 1'b1;
            enter_from = cur_e + 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (do_enter) begin
        if (found) begin
          cur_d = LW'(found_idx);
          left_d = found_len;
          col_d = {1'b0, found_offs};
          pos_d = '0;
          gb_d = '0;
        end else begin
          cur_d = enter_from;
          ph_d = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE;
      hdr_q <= '0;
      pos_q <= '0;
      asm_q <= '0;
      lines_q <= '0;
      cur_q <= '0;
      left_q <= '0;
      col_q <= '0;
      gb_q <= '0;
    end else begin
      ph_q <= ph_d;
      hdr_q <= hdr_d;
      pos_q <= pos_d;
      asm_q <= asm_d;
      lines_q <= lines_d;
      cur_q <= cur_d;
      left_q <= left_d;
      col_q <= col_d;
      gb_q <= gb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      len_tab_q[lines_q[IW-1:0]]  <= hdr_word[47:32];
      line_tab_q[lines_q[IW-1:0]] <= hdr_word[30:16];
      offs_tab_q[lines_q[IW-1:0]] <= hdr_word[14:0];
    end
  end
endmodule
`default_nettype wire

// ----- design/rvd_back.sv -----
`default_nettype none
module rvd_back import rvd_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire grp_t        grp_i,
  input  wire logic        grp_empty_i,
  output logic             grp_pop_o,
  input  wire logic [12:0] line_stride_i,
  input  wire logic [11:0] x_offset_i,
  input  wire logic [11:0] y_offset_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [23:0]      pixel_address_o,
  output logic [23:0]      pixel_rgb_o,
  output logic             last_of_group_o
);
  grp_t       grp_q;
  logic       gv_q, gv_d;
  logic [1:0] k_q, k_d;

  logic        s1_v_q, s1_v_d;
  logic [7:0]  s1_y_q, s1_cb_q, s1_cr_q;
  logic [14:0] s1_line_q;
  logic [15:0] s1_col_q;
  logic        s1_row_q, s1_cbit_q, s1_last_q;

  logic        s2_v_q, s2_v_d;
  logic [29:0] s2_prod_q;
  logic [16:0] s2_xsum_q;
  logic signed [27:0] s2_yy_q, s2_pr_q, s2_pgb_q, s2_pgr_q, s2_pb_q;
  logic        s2_last_q;

  logic        o_v_q, o_v_d;

  logic o_rdy, s2_take, s1_take, issue, load;

  assign o_rdy   = !o_v_q || pop_i;
  assign s2_take = !s2_v_q || o_rdy;
  assign s1_take = !s1_v_q || s2_take;
  assign issue   = gv_q && s1_take;
  assign load    = (!gv_q || (issue && k_q == 2'd3)) && !grp_empty_i;
  assign grp_pop_o = load;
  assign empty_o = !o_v_q;

  always_comb begin
    gv_d = gv_q;
    k_d = k_q;
    if (issue) begin
      k_d = k_q + 1'b1;
      if (k_q == 2'd3) begin
        gv_d = 1'b0;
      end
    end
    if (load) begin
      gv_d = 1'b1;
      k_d = '0;
    end
    s1_v_d = s1_take ? issue : s1_v_q;
    s2_v_d = s2_take ? s1_v_q : s2_v_q;
    o_v_d  = o_rdy ? s2_v_q : o_v_q;
  end

  // stage 2 arithmetic
  logic [16:0] rowsum;
  logic signed [27:0] r1x, b1x;
  logic [8:0] r1, b1;
  assign rowsum = 17'(s1_line_q) + 17'(y_offset_i) + 17'(s1_row_q);
  assign r1 = {1'b0, s1_cr_q} - CHROMA_MID;
  assign b1 = {1'b0, s1_cb_q} - CHROMA_MID;
  assign r1x = {{19{r1[8]}}, r1};
  assign b1x = {{19{b1[8]}}, b1};

  // output stage sums
  logic [30:0] asum;
  logic [23:0] amasked;
  logic signed [27:0] rs, gs, bs;
  assign asum = 31'(s2_prod_q) + 31'(s2_xsum_q);
  always_comb begin
    for (int i = 0; i < 24; i++) begin
      amasked[i] = (i < ADDR_BITS && i < 31) ? asum[i] : 1'b0;
    end
  end
  assign rs = s2_yy_q + s2_pr_q;
  assign gs = s2_yy_q - s2_pgb_q - s2_pgr_q;
  assign bs = s2_yy_q + s2_pb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gv_q <= 1'b0;
      k_q <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      gv_q <= gv_d;
      k_q <= k_d;
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
      o_v_q <= o_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      grp_q <= grp_i;
    end
    if (s1_take && issue) begin
      s1_y_q <= grp_q.ys[8*k_q +: 8];
      s1_cb_q <= grp_q.cb;
      s1_cr_q <= grp_q.cr;
      s1_line_q <= grp_q.line;
      s1_col_q <= grp_q.col;
      s1_row_q <= k_q[1];
      s1_cbit_q <= k_q[0];
      s1_last_q <= (k_q == 2'd3);
    end
    if (s2_take) begin
      s2_prod_q <= 30'(rowsum) * 30'(line_stride_i);
      s2_xsum_q <= 17'(x_offset_i) + 17'(s1_col_q) + 17'(s1_cbit_q);
      s2_yy_q <= $signed({4'd0, s1_y_q, s1_y_q, s1_y_q});
      s2_pr_q <= K_CR_R * r1x;
      s2_pgb_q <= K_CB_G * b1x;
      s2_pgr_q <= K_CR_G * r1x;
      s2_pb_q <= K_CB_B * b1x;
      s2_last_q <= s1_last_q;
    end
    if (o_rdy && s2_v_q) begin
      pixel_address_o <= amasked;
      pixel_rgb_o <= {clamp8(rs), clamp8(gs), clamp8(bs)};
      last_of_group_o <= s2_last_q;
    end
  end
endmodule
`default_nettype wire
